FILE: hw/rtl/pos3_pkg.sv
// Package with the constants, types and helper functions of the Poseidon width-3 block.
`timescale 1ns / 1ps

package pos3_pkg;

	localparam int ROUNDS = 30;
	localparam int FULL_ROUNDS_EACH_END = 4;
	localparam int WORD_BITS = 22;
	localparam int RC_DEPTH = ROUNDS * 3;
	localparam int RC_AW = 7;
	localparam int CNT_W = 5;

	typedef logic [WORD_BITS-1:0] word_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_MODULUS   = 3'd0,
		REG_INV_THREE = 3'd1,
		REG_INV_FOUR  = 3'd2,
		REG_INV_FIVE  = 3'd3,
		REG_INV_SIX   = 3'd4,
		REG_INV_SEVEN = 3'd5
	} reg_idx_t;

	// Input item kinds carried in tuser.
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_PERMUTE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_RC_RD,
		ST_RC_RED,
		ST_SBOX,
		ST_MDS,
		ST_OUT
	} state_t;

	// Modular addition of two words that are both below q.
	function automatic word_t add_mod(input word_t a, input word_t b, input word_t q);
		logic [WORD_BITS:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= {1'b0, q}) begin
			sum = sum - {1'b0, q};
		end
		return sum[WORD_BITS-1:0];
	endfunction

	// One step of the interleaved multiply: doubles the accumulator, adds b when the bit
	// is set and brings the sum back below q with at most two subtractions.
	function automatic word_t mul_step(input word_t acc, input logic bit_in, input word_t b,
			input word_t q);
		logic [WORD_BITS+1:0] t;
		logic [WORD_BITS+1:0] qx;
		qx = {2'b00, q};
		t = {1'b0, acc, 1'b0} + (bit_in ? {2'b00, b} : '0);
		if (t >= qx) begin
			t = t - qx;
		end
		if (t >= qx) begin
			t = t - qx;
		end
		return t[WORD_BITS-1:0];
	endfunction

endpackage

FILE: hw/rtl/poseidon_permutation_width3.sv
// Top level of the Poseidon width-3 permutation with one shared modular multiplier.
`timescale 1ns / 1ps

//  Channel   Direction  Moves
//  s_*       in         constant write or permute item (tuser selects)
//  m_*       out        permuted three-word state
//  APB       in/out     modulus and the five MDS inverses
//
// After a constant write the input stays ready for the next item. A permute runs 506
// modular multiplications one after another through the bit-serial multiplier, each of
// 22 steps. Reset clears control state, sets the modulus to 3 and the inverses to 1;
// the constant table is undefined until written.
// The input stays not ready from a permute transfer until its result transfer completes.
module poseidon_permutation_width3 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// const_index[6:0], const_value[28:7], word_zero[50:29], word_one[72:51],
	// word_two[94:73], zero fill[95]
	input  logic [95:0] s_tdata,
	// action[0]
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_zero[21:0], out_one[43:22], out_two[65:44], zero fill[71:66]
	output logic [71:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int WB = pos3_pkg::WORD_BITS;

	pos3_pkg::word_t modulus_q, inv_q [5];
	pos3_pkg::word_t q_eff, one_w;

	pos3_pkg::state_t state_q, state_d;
	logic ph_q;
	logic [2:0] k_q;
	logic [pos3_pkg::CNT_W-1:0] r_q;
	logic [1:0] i_q, j_q, step_q;
	pos3_pkg::word_t s_q [3];
	pos3_pkg::word_t t_q [3];
	pos3_pkg::word_t m_q [5];
	pos3_pkg::word_t tmp_q, acc_q, rc_q;
	pos3_pkg::word_t rc_mem [pos3_pkg::RC_DEPTH];

	// Shared multiplier state.
	pos3_pkg::word_t ma_q, mb_q, macc_q;
	logic [pos3_pkg::CNT_W-1:0] mcnt_q;
	logic mbusy_q, mdone_q;
	logic mul_start;
	pos3_pkg::word_t mul_a, mul_b;

	logic s_xfer, is_full, last_round;
	logic [pos3_pkg::RC_AW-1:0] wr_idx, rd_addr;
	logic [2:0] mds_sel;
	pos3_pkg::word_t add_res;

	assign pready = 1'b1;
	assign q_eff = (modulus_q == '0) ? pos3_pkg::word_t'(1) : modulus_q;
	assign one_w = (q_eff == pos3_pkg::word_t'(1)) ? '0 : pos3_pkg::word_t'(1);

	// Configuration writes and reads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= pos3_pkg::word_t'(3);
			for (int n = 0; n < 5; n++) begin
				inv_q[n] <= pos3_pkg::word_t'(1);
			end
		end else if (psel && penable && pwrite) begin
			unique case (paddr[4:2])
				pos3_pkg::REG_MODULUS:   modulus_q <= pwdata[WB-1:0];
				pos3_pkg::REG_INV_THREE: inv_q[0] <= pwdata[WB-1:0];
				pos3_pkg::REG_INV_FOUR:  inv_q[1] <= pwdata[WB-1:0];
				pos3_pkg::REG_INV_FIVE:  inv_q[2] <= pwdata[WB-1:0];
				pos3_pkg::REG_INV_SIX:   inv_q[3] <= pwdata[WB-1:0];
				pos3_pkg::REG_INV_SEVEN: inv_q[4] <= pwdata[WB-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[4:2])
			pos3_pkg::REG_MODULUS:   prdata[WB-1:0] = modulus_q;
			pos3_pkg::REG_INV_THREE: prdata[WB-1:0] = inv_q[0];
			pos3_pkg::REG_INV_FOUR:  prdata[WB-1:0] = inv_q[1];
			pos3_pkg::REG_INV_FIVE:  prdata[WB-1:0] = inv_q[2];
			pos3_pkg::REG_INV_SIX:   prdata[WB-1:0] = inv_q[3];
			pos3_pkg::REG_INV_SEVEN: prdata[WB-1:0] = inv_q[4];
			default: prdata = '0;
		endcase
	end

	assign s_tready = (state_q == pos3_pkg::ST_IDLE);
	assign s_xfer = s_tvalid && s_tready;
	assign wr_idx = s_tdata[6:0];
	assign rd_addr = pos3_pkg::RC_AW'({r_q, 1'b0}) + pos3_pkg::RC_AW'(r_q)
		+ pos3_pkg::RC_AW'(i_q);
	assign is_full = (r_q < pos3_pkg::CNT_W'(pos3_pkg::FULL_ROUNDS_EACH_END))
		|| (r_q >= pos3_pkg::CNT_W'(pos3_pkg::ROUNDS - pos3_pkg::FULL_ROUNDS_EACH_END));
	assign last_round = (r_q == pos3_pkg::CNT_W'(pos3_pkg::ROUNDS - 1));
	assign mds_sel = {1'b0, i_q} + {1'b0, j_q};

	// Round-constant table: written by write items, read into rc_q in the state before its use.
	always_ff @(posedge clk) begin
		if (s_xfer && s_tuser[0] == pos3_pkg::ACT_WRITE
				&& wr_idx < pos3_pkg::RC_AW'(pos3_pkg::RC_DEPTH)) begin
			rc_mem[wr_idx] <= s_tdata[28:7];
		end
		if (state_q == pos3_pkg::ST_RC_RD) begin
			rc_q <= rc_mem[rd_addr];
		end
	end

	// Next state and multiplier operand selection.
	always_comb begin
		state_d = state_q;
		mul_start = 1'b0;
		mul_a = '0;
		mul_b = one_w;
		unique case (state_q)
			pos3_pkg::ST_IDLE: begin
				if (s_xfer && s_tuser[0] == pos3_pkg::ACT_PERMUTE) begin
					state_d = pos3_pkg::ST_PREP;
				end
			end
			pos3_pkg::ST_PREP: begin
				mul_start = !ph_q;
				mul_a = (k_q < 3'd5) ? inv_q[k_q] : s_q[2'(k_q - 3'd5)];
				if (ph_q && mdone_q && k_q == 3'd7) begin
					state_d = pos3_pkg::ST_RC_RD;
				end
			end
			pos3_pkg::ST_RC_RD: state_d = pos3_pkg::ST_RC_RED;
			pos3_pkg::ST_RC_RED: begin
				mul_start = !ph_q;
				mul_a = rc_q;
				if (ph_q && mdone_q) begin
					state_d = (i_q == 2'd2) ? pos3_pkg::ST_SBOX : pos3_pkg::ST_RC_RD;
				end
			end
			pos3_pkg::ST_SBOX: begin
				mul_start = !ph_q;
				mul_a = (step_q == 2'd0) ? s_q[i_q] : tmp_q;
				mul_b = (step_q == 2'd1) ? tmp_q : s_q[i_q];
				if (ph_q && mdone_q && step_q == 2'd2 && !(is_full && i_q != 2'd2)) begin
					state_d = pos3_pkg::ST_MDS;
				end
			end
			pos3_pkg::ST_MDS: begin
				mul_start = !ph_q;
				mul_a = m_q[mds_sel];
				mul_b = s_q[j_q];
				if (ph_q && mdone_q && i_q == 2'd2 && j_q == 2'd2) begin
					state_d = last_round ? pos3_pkg::ST_OUT : pos3_pkg::ST_RC_RD;
				end
			end
			pos3_pkg::ST_OUT: begin
				if (m_tready) begin
					state_d = pos3_pkg::ST_IDLE;
				end
			end
			default: state_d = pos3_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pos3_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Bit-serial modular multiplier shared by every product of the permutation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mdone_q <= 1'b0;
			mcnt_q <= '0;
		end else begin
			mdone_q <= 1'b0;
			if (mul_start) begin
				mbusy_q <= 1'b1;
				mcnt_q <= '0;
			end else if (mbusy_q) begin
				mcnt_q <= mcnt_q + 1'b1;
				if (mcnt_q == pos3_pkg::CNT_W'(WB - 1)) begin
					mbusy_q <= 1'b0;
					mdone_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mul_start) begin
			ma_q <= mul_a;
			mb_q <= mul_b;
			macc_q <= '0;
		end else if (mbusy_q) begin
			macc_q <= pos3_pkg::mul_step(macc_q, ma_q[WB-1], mb_q, q_eff);
			ma_q <= {ma_q[WB-2:0], 1'b0};
		end
	end

	// Sequencer counters and phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= 1'b0;
			k_q <= '0;
			r_q <= '0;
			i_q <= '0;
			j_q <= '0;
			step_q <= '0;
		end else begin
			if (mul_start) begin
				ph_q <= 1'b1;
			end else if (mdone_q) begin
				ph_q <= 1'b0;
			end
			if (state_q == pos3_pkg::ST_IDLE) begin
				k_q <= '0;
				r_q <= '0;
				i_q <= '0;
				j_q <= '0;
				step_q <= '0;
			end else if (ph_q && mdone_q) begin
				unique case (state_q)
					pos3_pkg::ST_PREP: k_q <= k_q + 1'b1;
					pos3_pkg::ST_RC_RED: i_q <= (i_q == 2'd2) ? 2'd0 : i_q + 1'b1;
					pos3_pkg::ST_SBOX: begin
						if (step_q == 2'd2) begin
							step_q <= '0;
							i_q <= (is_full && i_q != 2'd2) ? i_q + 1'b1 : 2'd0;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
					pos3_pkg::ST_MDS: begin
						if (j_q == 2'd2) begin
							j_q <= '0;
							if (i_q == 2'd2) begin
								i_q <= '0;
								r_q <= r_q + 1'b1;
							end else begin
								i_q <= i_q + 1'b1;
							end
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	assign add_res = pos3_pkg::add_mod((state_q == pos3_pkg::ST_MDS) ? acc_q : s_q[i_q],
		macc_q, q_eff);

	// State words, reduced constants and the MDS accumulator.
	always_ff @(posedge clk) begin
		if (s_xfer && s_tuser[0] == pos3_pkg::ACT_PERMUTE) begin
			s_q[0] <= s_tdata[50:29];
			s_q[1] <= s_tdata[72:51];
			s_q[2] <= s_tdata[94:73];
		end else if (ph_q && mdone_q) begin
			unique case (state_q)
				pos3_pkg::ST_PREP: begin
					if (k_q < 3'd5) begin
						m_q[k_q] <= macc_q;
					end else begin
						s_q[2'(k_q - 3'd5)] <= macc_q;
					end
				end
				pos3_pkg::ST_RC_RED: s_q[i_q] <= add_res;
				pos3_pkg::ST_SBOX: begin
					if (step_q == 2'd2) begin
						s_q[i_q] <= macc_q;
					end else begin
						tmp_q <= macc_q;
					end
				end
				pos3_pkg::ST_MDS: begin
					if (j_q == 2'd2) begin
						acc_q <= '0;
						if (i_q == 2'd2) begin
							s_q[0] <= t_q[0];
							s_q[1] <= t_q[1];
							s_q[2] <= add_res;
						end else begin
							t_q[i_q] <= add_res;
						end
					end else begin
						acc_q <= add_res;
					end
				end
				default: ;
			endcase
		end else if (state_q == pos3_pkg::ST_RC_RD && r_q == '0 && i_q == '0) begin
			acc_q <= '0;
		end
	end

	assign m_tvalid = (state_q == pos3_pkg::ST_OUT);
	assign m_tdata = {6'b0, s_q[2], s_q[1], s_q[0]};

	// The multiplier runs only for the compute states.
	a_mul_in_compute: assert property (@(posedge clk) disable iff (!arst_n)
		mbusy_q |-> (state_q == pos3_pkg::ST_PREP || state_q == pos3_pkg::ST_RC_RED
			|| state_q == pos3_pkg::ST_SBOX || state_q == pos3_pkg::ST_MDS))
		else $error("multiplier busy outside a compute state");

	// No start is issued while a product is still being formed.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mbusy_q && !mdone_q)
		else $error("multiplier restarted while busy");

	// Input and output are never both open.
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while a result waits");

	// A completed result transfer returns the block to idle.
	a_out_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> s_tready)
		else $error("block not idle after result transfer");

endmodule
